FILE: rtl/alternating_color_shortest_path_defines.svh
// Assertion macros for the alternating color shortest path block.
// The asserting module provides clk_i and rst_ni.
`ifndef ALTERNATING_COLOR_SHORTEST_PATH_DEFINES_SVH
`define ALTERNATING_COLOR_SHORTEST_PATH_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define ACSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ACSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/acsp_pkg.sv
package acsp_pkg;

  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 512;
  localparam int MaxPasses = 2 * MaxNodes + 1;

  localparam int NodeW     = $clog2(MaxNodes);
  localparam int NodeCntW  = $clog2(MaxNodes + 1);
  localparam int CfgW      = 7;
  localparam int ModeW     = 2;
  localparam int DistW     = 8;
  localparam int DistDepth = 2 * MaxNodes;
  localparam int DistAw    = $clog2(DistDepth);
  localparam int EdgeW     = 1 + 2 * NodeW;
  localparam int EdgeAw    = $clog2(MaxEdges);
  localparam int FillW     = $clog2(MaxEdges + 1);
  localparam int PassW     = $clog2(MaxPasses + 1);

  localparam logic [DistW-1:0] Unreached = '1;

  localparam logic [ModeW-1:0] ModeRed  = 2'd0;
  localparam logic [ModeW-1:0] ModeBlue = 2'd1;
  localparam logic [ModeW-1:0] ModeRun  = 2'd2;

  // sequencer step addresses
  typedef logic [3:0] step_t;
  localparam step_t StIdle  = 4'd0;
  localparam step_t StInit  = 4'd1;
  localparam step_t StERead = 4'd2;
  localparam step_t StEDec  = 4'd3;
  localparam step_t StDu    = 4'd4;
  localparam step_t StDv    = 4'd5;
  localparam step_t StNext  = 4'd6;
  localparam step_t StOa    = 4'd7;
  localparam step_t StOb    = 4'd8;
  localparam step_t StOc    = 4'd9;
  localparam step_t StOd    = 4'd10;
  localparam step_t StFin   = 4'd11;

  typedef enum logic [1:0] {
    DsU = 2'd0,  // {from, other color}
    DsV = 2'd1,  // {to, edge color}
    DsA = 2'd2,  // {node, red}
    DsB = 2'd3   // {node, blue}
  } dist_sel_e;

  typedef enum logic [3:0] {
    CNone      = 4'd0,
    CAlways    = 4'd1,
    CNoRun     = 4'd2,
    CFillZero  = 4'd3,
    COutRange  = 4'd4,
    CUnreached = 4'd5,
    CMoreEdge  = 4'd6,
    COutBusy   = 4'd7,
    CMoreNode  = 4'd8
  } cond_e;

  typedef struct packed {
    logic      in_rdy;
    logic      init;
    logic      edge_re;
    logic      dist_re;
    dist_sel_e dist_sel;
    logic      cap_du;
    logic      relax;
    logic      edge_adv;
    logic      cap_a;
    logic      out_load;
    logic      fill_clr;
    cond_e     cond;
    step_t     target;
  } ctrl_t;

  function automatic ctrl_t ctrl_rom(step_t step);
    ctrl_t c;
    c = '{in_rdy: 1'b0, init: 1'b0, edge_re: 1'b0, dist_re: 1'b0, dist_sel: DsU,
          cap_du: 1'b0, relax: 1'b0, edge_adv: 1'b0, cap_a: 1'b0, out_load: 1'b0,
          fill_clr: 1'b0, cond: CNone, target: StIdle};
    unique case (step)
      StIdle: begin
        c.in_rdy = 1'b1;
        c.cond   = CNoRun;
        c.target = StIdle;
      end
      StInit: begin
        c.init   = 1'b1;
        c.cond   = CFillZero;
        c.target = StOa;
      end
      StERead: begin
        c.edge_re = 1'b1;
      end
      StEDec: begin
        c.dist_re  = 1'b1;
        c.dist_sel = DsU;
        c.cond     = COutRange;
        c.target   = StNext;
      end
      StDu: begin
        c.dist_re  = 1'b1;
        c.dist_sel = DsV;
        c.cap_du   = 1'b1;
        c.cond     = CUnreached;
        c.target   = StNext;
      end
      StDv: begin
        c.relax = 1'b1;
      end
      StNext: begin
        c.edge_adv = 1'b1;
        c.cond     = CMoreEdge;
        c.target   = StERead;
      end
      StOa: begin
        c.dist_re  = 1'b1;
        c.dist_sel = DsA;
      end
      StOb: begin
        c.dist_re  = 1'b1;
        c.dist_sel = DsB;
        c.cap_a    = 1'b1;
      end
      StOc: begin
        c.out_load = 1'b1;
        c.cond     = COutBusy;
        c.target   = StOc;
      end
      StOd: begin
        c.cond   = CMoreNode;
        c.target = StOa;
      end
      StFin: begin
        c.fill_clr = 1'b1;
        c.cond     = CAlways;
        c.target   = StIdle;
      end
      default: begin
        c.cond   = CAlways;
        c.target = StIdle;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/acsp_in_if.sv
interface acsp_in_if;
  logic                            valid;
  logic                            ready;
  logic [acsp_pkg::ModeW-1:0]      mode;
  logic [acsp_pkg::NodeW-1:0]      from_node;
  logic [acsp_pkg::NodeW-1:0]      to_node;

  modport source (output valid, mode, from_node, to_node, input ready);
  modport sink   (input valid, mode, from_node, to_node, output ready);
endinterface

FILE: rtl/acsp_out_if.sv
interface acsp_out_if;
  logic                              valid;
  logic                              ready;
  logic [acsp_pkg::NodeW-1:0]        node_index;
  logic signed [acsp_pkg::DistW-1:0] distance;
  logic                              edges_dropped;
  logic                              last;

  modport source (output valid, node_index, distance, edges_dropped, last, input ready);
  modport sink   (input valid, node_index, distance, edges_dropped, last, output ready);
endinterface

FILE: rtl/acsp_ram.sv
module acsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/alternating_color_shortest_path.sv
// Alternating color shortest path engine. Requests with mode red or blue add one
// directed edge each to a 512-entry edge store and, while idle, are taken one
// per cycle; an edge that finds the store full is dropped and sets a sticky
// edges_dropped flag that only reset clears. A run request computes, for every
// node below node_count (0 acts as 1, above 64 acts as 64), the fewest edges on
// a path from node 0 whose colors alternate, and returns one result per node in
// node order, -1 for nodes that cannot be reached, last set on the final node;
// the edge store is then empty. Edges with an end outside the nodes in use stay
// stored but are ignored. A run is done by a small microcoded sequencer sweeping
// the edge store in relaxation passes until a pass changes nothing (at most 129
// passes). Each edge is read and skipped when an end is outside the nodes in
// use; else its source distance is read and, when reached, its target distance
// is read and relaxed, one read at a time through the single registered read
// port of the distance table. Results then go out node by node, held on a stall.
// No requests are taken during a run; configuration may be written while idle.
// The distance table starts every run empty through per-entry valid bits, so
// there is no clearing pass.

`include "alternating_color_shortest_path_defines.svh"

module alternating_color_shortest_path (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acsp_pkg::CfgW-1:0]     cfg_wdata_i,
  acsp_in_if.sink                       req_i,
  acsp_out_if.source                    res_o
);

  localparam int NodeW    = acsp_pkg::NodeW;
  localparam int NodeCntW = acsp_pkg::NodeCntW;
  localparam int DistW    = acsp_pkg::DistW;
  localparam int DistAw   = acsp_pkg::DistAw;
  localparam int EdgeW    = acsp_pkg::EdgeW;
  localparam int EdgeAw   = acsp_pkg::EdgeAw;
  localparam int FillW    = acsp_pkg::FillW;
  localparam int PassW    = acsp_pkg::PassW;

  // ---------------------------------------------------------------------------
  // Configuration: node count and its clamped effective value
  // ---------------------------------------------------------------------------
  logic [acsp_pkg::CfgW-1:0] node_cnt_q;
  logic [NodeCntW-1:0]       nodes_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= acsp_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      node_cnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (node_cnt_q == '0) begin
      nodes_eff = NodeCntW'(1);
    end else if (32'(node_cnt_q) > acsp_pkg::MaxNodes) begin
      nodes_eff = NodeCntW'(acsp_pkg::MaxNodes);
    end else begin
      nodes_eff = NodeCntW'(node_cnt_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter, control word from ROM, conditional jump
  // ---------------------------------------------------------------------------
  acsp_pkg::step_t step_q, step_d;
  acsp_pkg::ctrl_t ctrl;
  logic            jump;

  assign ctrl = acsp_pkg::ctrl_rom(step_q);

  // request handshake
  logic req_acc, run_acc, edge_acc;
  assign req_i.ready = ctrl.in_rdy;
  assign req_acc     = req_i.valid && ctrl.in_rdy;
  assign run_acc     = req_acc && (req_i.mode == acsp_pkg::ModeRun);
  assign edge_acc    = req_acc && ((req_i.mode == acsp_pkg::ModeRed) ||
                                   (req_i.mode == acsp_pkg::ModeBlue));

  // ---------------------------------------------------------------------------
  // Edge store
  // ---------------------------------------------------------------------------
  logic [FillW-1:0]  fill_q;
  logic              dropped_q;
  logic [EdgeAw-1:0] k_q;
  logic [EdgeW-1:0]  edge_rdata;
  logic              edge_we;
  logic              store_full;

  assign store_full = (32'(fill_q) == acsp_pkg::MaxEdges);
  assign edge_we    = edge_acc && !store_full;

  acsp_ram #(
    .Width (EdgeW),
    .Depth (acsp_pkg::MaxEdges)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (fill_q[EdgeAw-1:0]),
    .wdata_i ({req_i.mode[0], req_i.from_node, req_i.to_node}),
    .re_i    (ctrl.edge_re),
    .raddr_i (k_q),
    .rdata_o (edge_rdata)
  );

  // read data holds between edge reads, so fields are used straight from the RAM
  logic             e_color;
  logic [NodeW-1:0] e_u, e_v;
  logic             e_in_range;

  assign e_color    = edge_rdata[EdgeW-1];
  assign e_u        = edge_rdata[2*NodeW-1:NodeW];
  assign e_v        = edge_rdata[NodeW-1:0];
  assign e_in_range = (NodeCntW'(e_u) < nodes_eff) && (NodeCntW'(e_v) < nodes_eff);

  // ---------------------------------------------------------------------------
  // Distance table: index {node, color of last edge}
  // ---------------------------------------------------------------------------
  logic [acsp_pkg::DistDepth-1:0] vld_q;
  logic [DistAw-1:0]              dist_raddr, dist_waddr;
  logic [DistW-1:0]               dist_rdata, dist_wdata, rd_val;
  logic                           dist_we;
  logic                           rd_zero_q, rd_vld_q;
  logic [NodeCntW-1:0]            i_q;

  always_comb begin
    unique case (ctrl.dist_sel)
      acsp_pkg::DsU: dist_raddr = {e_u, ~e_color};
      acsp_pkg::DsV: dist_raddr = {e_v, e_color};
      acsp_pkg::DsA: dist_raddr = {i_q[NodeW-1:0], 1'b0};
      acsp_pkg::DsB: dist_raddr = {i_q[NodeW-1:0], 1'b1};
      default:       dist_raddr = '0;
    endcase
  end

  acsp_ram #(
    .Width (DistW),
    .Depth (acsp_pkg::DistDepth)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (ctrl.dist_re),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // node 0 always reads 0 in both colors; an entry not written this run is unreached
  always_ff @(posedge clk_i) begin
    if (ctrl.dist_re) begin
      rd_zero_q <= (dist_raddr[DistAw-1:1] == '0);
      rd_vld_q  <= vld_q[dist_raddr];
    end
  end

  assign rd_val = rd_zero_q ? '0 : (rd_vld_q ? dist_rdata : acsp_pkg::Unreached);

  // relaxation of one edge
  logic [DistW-1:0] du_q, nd;
  logic             relax_ok;

  assign nd         = du_q + DistW'(1);
  assign relax_ok   = (nd != acsp_pkg::Unreached) && (nd < rd_val);
  assign dist_we    = ctrl.relax && relax_ok;
  assign dist_waddr = {e_v, e_color};
  assign dist_wdata = nd;

  // ---------------------------------------------------------------------------
  // Pass bookkeeping
  // ---------------------------------------------------------------------------
  logic [PassW-1:0] pass_q;
  logic             changed_q;
  logic             edge_last, pass_go;

  assign edge_last = ((FillW'(k_q) + FillW'(1)) == fill_q);
  assign pass_go   = changed_q &&
                     ((pass_q + PassW'(1)) < PassW'(acsp_pkg::MaxPasses));

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             out_vld_q, slot_free, out_load;
  logic [NodeW-1:0] out_node_q;
  logic [DistW-1:0] out_dist_q, a_q, d_min;
  logic             out_drop_q, out_last_q;

  assign slot_free = !out_vld_q || res_o.ready;
  assign out_load  = ctrl.out_load && slot_free;
  assign d_min     = (a_q < rd_val) ? a_q : rd_val;

  assign res_o.valid         = out_vld_q;
  assign res_o.node_index    = out_node_q;
  assign res_o.distance      = $signed(out_dist_q);
  assign res_o.edges_dropped = out_drop_q;
  assign res_o.last          = out_last_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.cap_du) begin
      du_q <= rd_val;
    end
    if (ctrl.cap_a) begin
      a_q <= rd_val;
    end
    if (out_load) begin
      out_node_q <= i_q[NodeW-1:0];
      out_dist_q <= d_min;
      out_drop_q <= dropped_q;
      out_last_q <= ((i_q + NodeCntW'(1)) == nodes_eff);
    end
  end

  // ---------------------------------------------------------------------------
  // Next step
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (ctrl.cond)
      acsp_pkg::CNone:      jump = 1'b0;
      acsp_pkg::CAlways:    jump = 1'b1;
      acsp_pkg::CNoRun:     jump = !run_acc;
      acsp_pkg::CFillZero:  jump = (fill_q == '0);
      acsp_pkg::COutRange:  jump = !e_in_range;
      acsp_pkg::CUnreached: jump = (rd_val == acsp_pkg::Unreached);
      acsp_pkg::CMoreEdge:  jump = !edge_last || pass_go;
      acsp_pkg::COutBusy:   jump = !slot_free;
      acsp_pkg::CMoreNode:  jump = (i_q != nodes_eff);
      default:              jump = 1'b1;
    endcase
    step_d = jump ? ctrl.target : step_q + acsp_pkg::step_t'(1);
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= acsp_pkg::StIdle;
      fill_q    <= '0;
      dropped_q <= 1'b0;
      k_q       <= '0;
      pass_q    <= '0;
      changed_q <= 1'b0;
      i_q       <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      step_q <= step_d;

      if (edge_we) begin
        fill_q <= fill_q + FillW'(1);
      end else if (ctrl.fill_clr) begin
        fill_q <= '0;
      end
      if (edge_acc && store_full) begin
        dropped_q <= 1'b1;
      end

      if (ctrl.init) begin
        k_q       <= '0;
        pass_q    <= '0;
        changed_q <= 1'b0;
        i_q       <= '0;
        vld_q     <= '0;
      end else begin
        if (dist_we) begin
          vld_q[dist_waddr] <= 1'b1;
          changed_q         <= 1'b1;
        end
        if (ctrl.edge_adv) begin
          if (edge_last) begin
            k_q       <= '0;
            pass_q    <= pass_q + PassW'(1);
            changed_q <= 1'b0;
          end else begin
            k_q <= k_q + EdgeAw'(1);
          end
        end
        if (out_load) begin
          i_q <= i_q + NodeCntW'(1);
        end
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ACSP_ASSERT(a_fill_bound, 32'(fill_q) <= acsp_pkg::MaxEdges, "edge fill beyond store")
  `ACSP_ASSERT(a_node0_fixed, !dist_we || (dist_waddr[DistAw-1:1] != '0), "node 0 relaxed")
  `ACSP_ASSERT_NEXT(a_fin_empty, step_q == acsp_pkg::StFin, fill_q == '0, "store not emptied")
  `ACSP_ASSERT(a_res_src, !$rose(out_vld_q) || $past(step_q == acsp_pkg::StOc), "stray result")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MaxNodes = acsp_pkg::MaxNodes;
  localparam int MaxEdges = acsp_pkg::MaxEdges;
  localparam int NodeW    = acsp_pkg::NodeW;
  localparam int DistW    = acsp_pkg::DistW;
  localparam int CfgW     = acsp_pkg::CfgW;
  localparam int ModeW    = acsp_pkg::ModeW;

  localparam logic [ModeW-1:0] ModeRed  = acsp_pkg::ModeRed;
  localparam logic [ModeW-1:0] ModeBlue = acsp_pkg::ModeBlue;
  localparam logic [ModeW-1:0] ModeRun  = acsp_pkg::ModeRun;

  // Mode 3 is not decoded by the block: accepted and dropped.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  localparam int RandomRequests = 120;
  // After a run's last result the sequencer still steps through StOd and StFin before it is back in idle.
  localparam int SettleCycles   = 16;
  // Longest quiet stretch: a full 512-arc store over 8 nodes needs at most
  // 17 sweeps over every arc; the limit is set several times above such a run.
  localparam int IdleLimit      = 250_000;
  localparam int ReportLimit    = 10;

  typedef struct packed {
    logic             blue;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
  } arc_t;

  typedef struct packed {
    logic [NodeW-1:0]        node;
    logic signed [DistW-1:0] distance;
    logic                    dropped;
    logic                    last;
  } node_dist_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  acsp_in_if  req_if ();
  acsp_out_if res_if ();

  alternating_color_shortest_path dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // Mirror of the block's graph: arcs held, sticky overflow, node count.
  arc_t            arc_store [MaxEdges];
  int unsigned     arc_fill;
  logic            arcs_dropped;
  logic [CfgW-1:0] node_count_q;

  // Distances still owed by the block, oldest first.
  node_dist_t expected_dist_q [$];
  node_dist_t oldest_dist;

  int mismatches;
  int idle_cycles;
  bit no_idle;  // when set, neither side inserts gaps

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 0 behaves as 1, anything above the node capacity as the capacity.
  function automatic int active_nodes(logic [CfgW-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > MaxNodes) return MaxNodes;
    return int'(cnt);
  endfunction

  // Applies one accepted request to the mirror. An arc request grows the
  // store (or sets the overflow flag when full). A run request does a
  // level-by-level breadth-first search over (node, color of last arc) and
  // queues one distance per node in use, then empties the store.
  task automatic predict_request(logic [ModeW-1:0] mode, logic [NodeW-1:0] src,
                                 logic [NodeW-1:0] dst);
    int         hops [MaxNodes][2];
    int         nodes;
    int         lvl;
    int         best;
    int         k;
    bit         grew;
    arc_t       a;
    node_dist_t res;
    if (mode == ModeRed || mode == ModeBlue) begin
      if (arc_fill < MaxEdges) begin
        arc_store[arc_fill] = '{blue: (mode == ModeBlue), src: src, dst: dst};
        arc_fill++;
      end else begin
        arcs_dropped = 1'b1;
      end
    end else if (mode == ModeRun) begin
      nodes = active_nodes(node_count_q);
      foreach (hops[i, c]) hops[i][c] = -1;
      // node 0 may leave on either color
      hops[0][0] = 0;
      hops[0][1] = 0;
      lvl  = 0;
      grew = 1'b1;
      while (grew) begin
        grew = 1'b0;
        for (k = 0; k < arc_fill; k++) begin
          a = arc_store[k];
          // arcs touching a node outside the count stay stored but are skipped
          if (a.src >= nodes || a.dst >= nodes) continue;
          // a red arc must follow a blue one and vice versa
          if (hops[a.src][!a.blue] == lvl && hops[a.dst][a.blue] < 0) begin
            hops[a.dst][a.blue] = lvl + 1;
            grew = 1'b1;
          end
        end
        lvl++;
      end
      for (int i = 0; i < nodes; i++) begin
        best = hops[i][0];
        if (best < 0 || (hops[i][1] >= 0 && hops[i][1] < best)) best = hops[i][1];
        res.node     = NodeW'(i);
        res.distance = (best < 0) ? {DistW{1'b1}} : DistW'(best);
        res.dropped  = arcs_dropped;
        res.last     = (i == nodes - 1);
        expected_dist_q = {expected_dist_q, res};
      end
      arc_fill = 0;
    end
  endtask

  // Presents one request after an optional gap and holds it until taken.
  // Valid stays high on return so back-to-back requests need no bubble.
  task automatic send_request(logic [ModeW-1:0] mode, logic [NodeW-1:0] src,
                              logic [NodeW-1:0] dst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= mode;
    req_if.from_node <= src;
    req_if.to_node   <= dst;
    do @(posedge clk); while (!req_if.ready);
    predict_request(mode, src, dst);
  endtask

  // Stop requesting and let every owed distance come back, then let the
  // sequencer return to idle.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    node_count_q = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Straight after reset: node count is 1 and the store is empty.
  task automatic test_empty_graph();
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
  endtask

  // Color alternation, same-color chains, loops back to node 0, self loop,
  // and an unused mode that must be swallowed.
  task automatic test_alternating_colors();
    write_node_count(7'd64);
    send_request(ModeRed, 6'd0, 6'd1);
    send_request(ModeBlue, 6'd1, 6'd2);
    send_request(ModeRed, 6'd2, 6'd63);
    send_request(ModeBlue, 6'd0, 6'd3);
    send_request(ModeBlue, 6'd3, 6'd4);    // blue after blue: 4 not reached
    send_request(ModeUnused, 6'd63, 6'd63);
    send_request(ModeRed, 6'd63, 6'd0);    // back into the start node
    send_request(ModeBlue, 6'd4, 6'd5);
    send_request(ModeRed, 6'd62, 6'd62);
    send_request(ModeBlue, 6'd63, 6'd61);
    send_request(ModeRun, 6'd63, 6'd63);
    wait_for_results();
  endtask

  // Node count extremes and arcs with an end outside the nodes in use.
  task automatic test_node_count_limits();
    write_node_count(7'd0);
    send_request(ModeRed, 6'd0, 6'd1);
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
    write_node_count(7'd3);
    send_request(ModeRed, 6'd0, 6'd2);
    send_request(ModeBlue, 6'd2, 6'd40);
    send_request(ModeRed, 6'd40, 6'd1);
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
    write_node_count(7'd127);
    send_request(ModeBlue, 6'd0, 6'd63);
    send_request(ModeRed, 6'd63, 6'd62);
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
    write_node_count(7'd65);
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
  endtask

  // Random graphs. Roughly a third of the phases walk an alternating chain
  // from node 0 so that distances go deep; the rest scatter arcs, mostly
  // inside the node count, with some stray arcs and unused-mode noise.
  task automatic test_random_graphs();
    int               sent;
    int               nodes;
    int               n_arcs;
    bit               chain;
    logic [NodeW-1:0] cur;
    logic [NodeW-1:0] nxt;
    logic             blue;
    logic [CfgW-1:0]  cnt;
    sent = 0;
    while (sent < RandomRequests) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_for_results();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cnt = CfgW'($urandom_range(2, 12));
          6, 7:             cnt = CfgW'($urandom_range(1, 64));
          8:                cnt = CfgW'($urandom_range(65, 127));
          default:          cnt = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd127;
        endcase
        write_node_count(cnt);
      end
      nodes  = active_nodes(node_count_q);
      n_arcs = $urandom_range(0, 20);
      chain  = ($urandom_range(0, 2) == 0);
      cur    = '0;
      blue   = 1'($urandom_range(0, 1));
      for (int j = 0; j < n_arcs; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(ModeUnused, NodeW'($urandom_range(0, 63)),
                       NodeW'($urandom_range(0, 63)));
        end else if (chain && $urandom_range(0, 4) != 0) begin
          nxt = NodeW'($urandom_range(0, nodes - 1));
          send_request(blue ? ModeBlue : ModeRed, cur, nxt);
          cur  = nxt;
          blue = !blue;
          sent++;
        end else if ($urandom_range(0, 5) == 0) begin
          send_request(ModeW'($urandom_range(0, 1)), NodeW'($urandom_range(0, 63)),
                       NodeW'($urandom_range(0, 63)));
          sent++;
        end else begin
          send_request(ModeW'($urandom_range(0, 1)), NodeW'($urandom_range(0, nodes - 1)),
                       NodeW'($urandom_range(0, nodes - 1)));
          sent++;
        end
      end
      send_request(ModeRun, NodeW'($urandom_range(0, 63)), NodeW'($urandom_range(0, 63)));
      sent++;
      // now and then hold the next request back until the run has drained
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Fill past capacity: the overflow flag must show on this run and stay set
  // on the next, while the run still empties the store.
  task automatic test_store_overflow();
    write_node_count(7'd8);
    no_idle = 1'b1;
    send_request(ModeRed, 6'd0, 6'd1);
    for (int j = 0; j < MaxEdges + 6; j++) begin
      send_request(ModeW'($urandom_range(0, 1)), NodeW'($urandom_range(0, 7)),
                   NodeW'($urandom_range(0, 7)));
    end
    no_idle = 1'b0;
    send_request(ModeRun, 6'd0, 6'd0);
    send_request(ModeBlue, 6'd0, 6'd7);
    send_request(ModeRed, 6'd7, 6'd6);
    send_request(ModeRun, 6'd0, 6'd0);
    wait_for_results();
  endtask

  // Result side: draw a stall before each result, then take it.
  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Every accepted result is checked against the oldest owed distance.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: node %0d distance %0d dropped %0b last %0b",
                   res_if.node_index, res_if.distance, res_if.edges_dropped, res_if.last);
      end else begin
        oldest_dist = expected_dist_q.pop_front();
        if (res_if.node_index !== oldest_dist.node ||
            res_if.distance !== oldest_dist.distance ||
            res_if.edges_dropped !== oldest_dist.dropped ||
            res_if.last !== oldest_dist.last) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("result mismatch: exp node %0d dist %0d drop %0b last %0b, got %0d %0d %0b %0b",
                     oldest_dist.node, oldest_dist.distance, oldest_dist.dropped,
                     oldest_dist.last, res_if.node_index, res_if.distance,
                     res_if.edges_dropped, res_if.last);
        end
      end
    end
  end

  // Watchdog: too long without a request or result moving means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.mode      <= ModeRed;
    req_if.from_node <= '0;
    req_if.to_node   <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    arc_fill     = 0;
    arcs_dropped = 1'b0;
    node_count_q = 7'd1;
    mismatches   = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_graph();
    test_alternating_colors();
    test_node_count_limits();
    test_random_graphs();
    test_store_overflow();

    wait_for_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
